// File: hdl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared codes, character constants, result types and method tables.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam logic [3:0] EV_NONE         = 4'd0;
	localparam logic [3:0] EV_METHOD       = 4'd1;
	localparam logic [3:0] EV_URL_BYTE     = 4'd2;
	localparam logic [3:0] EV_URL_END      = 4'd3;
	localparam logic [3:0] EV_NAME_BYTE    = 4'd4;
	localparam logic [3:0] EV_VALUE_BYTE   = 4'd5;
	localparam logic [3:0] EV_FIELD_END    = 4'd6;
	localparam logic [3:0] EV_LINE_SKIPPED = 4'd7;
	localparam logic [3:0] EV_HEADERS_DONE = 4'd8;
	localparam logic [3:0] EV_ERROR        = 4'd9;

	localparam logic [3:0] PH_METHOD     = 4'd0;
	localparam logic [3:0] PH_SPACE      = 4'd1;
	localparam logic [3:0] PH_PATH       = 4'd2;
	localparam logic [3:0] PH_PROTO      = 4'd3;
	localparam logic [3:0] PH_SKIP       = 4'd4;
	localparam logic [3:0] PH_LINE_START = 4'd5;
	localparam logic [3:0] PH_NAME       = 4'd6;
	localparam logic [3:0] PH_VALUE      = 4'd7;
	localparam logic [3:0] PH_DONE       = 4'd8;
	localparam logic [3:0] PH_ERROR      = 4'd9;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_PCT   = 8'h25;

	localparam int unsigned NumMethods = 8;
	localparam logic [7:0] BASIC_METHOD_MASK = 8'h1f;
	localparam logic [2:0] PROTO_LEN = 3'd5;

	localparam logic [63:0] METHOD_TEXT [NumMethods] = '{
		{"GET", 40'h0}, {"HEAD", 32'h0}, {"POST", 32'h0}, {"PUT", 40'h0},
		{"DELETE", 16'h0}, {"CONNECT", 8'h0}, {"OPTIONS", 8'h0}, {"TRACE", 24'h0}
	};
	localparam logic [39:0] PROTO_TEXT = "HTTP/";

	typedef struct packed {
		logic [3:0] ev;
		logic [7:0] data;
		logic [2:0] method;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} pair_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] cand;
		logic [2:0] pos;
		logic [2:0] mfound;
		logic [7:0] esc_val;
		logic [1:0] esc_dig;
		logic       hcolon;
		logic       hcr;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_METHOD, cand: 8'hff, pos: 3'd0, mfound: 3'd0,
		esc_val: 8'h00, esc_dig: 2'd0, hcolon: 1'b0, hcr: 1'b0
	};

	function automatic logic [2:0] method_len(input logic [2:0] idx);
		logic [2:0] len;
		case (idx)
			3'd0: len = 3'd3;
			3'd1: len = 3'd4;
			3'd2: len = 3'd4;
			3'd3: len = 3'd3;
			3'd4: len = 3'd6;
			3'd5: len = 3'd7;
			3'd6: len = 3'd7;
			default: len = 3'd5;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] method_char(input logic [63:0] text, input logic [2:0] pos);
		return text[(7 - int'(pos)) * 8 +: 8];
	endfunction

	function automatic logic [7:0] proto_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = PROTO_TEXT[39:32];
			3'd1: c = PROTO_TEXT[31:24];
			3'd2: c = PROTO_TEXT[23:16];
			3'd3: c = PROTO_TEXT[15:8];
			3'd4: c = PROTO_TEXT[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
		else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
		else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
		else r = 5'd0;
		return r;
	endfunction

endpackage

// File: hdl/hrhp_in_if.sv
// ----------------------------------------------------------------------------
// Request byte channel
// Valid/ready channel carrying one request byte and its start marker.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_request;

	modport source (output valid, output data_byte, output start_of_request, input ready);
	modport sink (input valid, input data_byte, input start_of_request, output ready);
endinterface

// File: hdl/hrhp_out_if.sv
// ----------------------------------------------------------------------------
// Parse event channel
// Valid/ready channel carrying one parse event item.
// ----------------------------------------------------------------------------
interface hrhp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_res;
	logic [7:0] out_byte;
	logic [2:0] method_code;
	logic       last;

	modport source (output valid, output event_res, output out_byte, output method_code,
		output last, input ready);
	modport sink (input valid, input event_res, input out_byte, input method_code,
		input last, output ready);
endinterface

// File: hdl/hrhp_step.sv
// ----------------------------------------------------------------------------
// Parser step logic
// Next parser state and the one or two events caused by one request byte.
// ----------------------------------------------------------------------------
module hrhp_step import hrhp_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         start_of_request,
	input  logic         ext_en,
	output parse_state_t nxt,
	output pair_t        res
);

	function automatic pair_t emit(input pair_t p, input logic [3:0] ev, input logic [7:0] d);
		pair_t q;
		q = p;
		if (p.cnt == 2'd0) begin
			q.r0.ev = ev;
			q.r0.data = d;
			q.cnt = 2'd1;
		end else if (p.cnt == 2'd1) begin
			q.r1.ev = ev;
			q.r1.data = d;
			q.cnt = 2'd2;
		end
		return q;
	endfunction

	function automatic void go_error(inout parse_state_t s, inout pair_t p);
		s.phase = PH_ERROR;
		s.esc_dig = 2'd0;
		s.esc_val = 8'h00;
		s.hcolon = 1'b0;
		s.hcr = 1'b0;
		p = emit(p, EV_ERROR, 8'h00);
	endfunction

	function automatic void method_step(input logic [7:0] b, input logic en,
		inout parse_state_t s, inout pair_t p);
		logic [7:0] cand;
		logic [7:0] keep;
		logic [7:0] done;
		logic [2:0] sel;
		cand = s.cand & (en ? 8'hff : BASIC_METHOD_MASK);
		keep = 8'h00;
		done = 8'h00;
		sel = 3'd0;
		for (int i = 0; i < NumMethods; i++) begin
			if (cand[i] && method_len(3'(i)) > s.pos
				&& method_char(METHOD_TEXT[i], s.pos) == b) begin
				keep[i] = 1'b1;
				done[i] = (method_len(3'(i)) == s.pos + 3'd1);
			end
		end
		for (int i = NumMethods - 1; i >= 0; i--) begin
			if (done[i]) sel = 3'(i);
		end
		if (done != 8'h00) begin
			s.mfound = sel;
			s.phase = PH_SPACE;
			p = emit(p, EV_METHOD, 8'h00);
		end else if (keep == 8'h00) begin
			go_error(s, p);
		end else begin
			s.cand = keep;
			s.pos = s.pos + 3'd1;
		end
	endfunction

	function automatic void path_step(input logic [7:0] b, inout parse_state_t s,
		inout pair_t p);
		logic [4:0] hv;
		hv = hex_value(b);
		if (s.esc_dig != 2'd0) begin
			if (hv[4]) begin
				s.esc_val = {s.esc_val[3:0], hv[3:0]};
				if (s.esc_dig == 2'd2) begin
					p = emit(p, EV_URL_BYTE, s.esc_val);
					s.esc_dig = 2'd0;
					s.esc_val = 8'h00;
				end else begin
					s.esc_dig = 2'd2;
				end
				return;
			end
			p = emit(p, EV_URL_BYTE, s.esc_val);
			s.esc_dig = 2'd0;
			s.esc_val = 8'h00;
		end else if (s.hcr) begin
			s.hcr = 1'b0;
			if (b == CH_LF) begin
				go_error(s, p);
				return;
			end
			p = emit(p, EV_URL_BYTE, CH_CR);
		end
		if (b == CH_SP) begin
			p = emit(p, EV_URL_END, 8'h00);
			s.phase = PH_PROTO;
			s.pos = 3'd0;
		end else if (b == CH_PCT) begin
			s.esc_dig = 2'd1;
			s.esc_val = 8'h00;
		end else if (b == CH_CR) begin
			s.hcr = 1'b1;
		end else begin
			p = emit(p, EV_URL_BYTE, b);
		end
	endfunction

	function automatic void name_step(input logic [7:0] b, inout parse_state_t s,
		inout pair_t p);
		if (s.hcolon) begin
			s.hcolon = 1'b0;
			if (b == CH_SP) begin
				s.phase = PH_VALUE;
				return;
			end
			p = emit(p, EV_NAME_BYTE, CH_COLON);
		end else if (s.hcr) begin
			s.hcr = 1'b0;
			if (b == CH_LF) begin
				p = emit(p, EV_LINE_SKIPPED, 8'h00);
				s.phase = PH_LINE_START;
				return;
			end
			p = emit(p, EV_NAME_BYTE, CH_CR);
		end
		if (b == CH_COLON) s.hcolon = 1'b1;
		else if (b == CH_CR) s.hcr = 1'b1;
		else p = emit(p, EV_NAME_BYTE, b);
	endfunction

	function automatic void value_step(input logic [7:0] b, inout parse_state_t s,
		inout pair_t p);
		if (s.hcr) begin
			s.hcr = 1'b0;
			if (b == CH_LF) begin
				p = emit(p, EV_FIELD_END, 8'h00);
				s.phase = PH_LINE_START;
				return;
			end
			p = emit(p, EV_VALUE_BYTE, CH_CR);
		end
		if (b == CH_CR) s.hcr = 1'b1;
		else p = emit(p, EV_VALUE_BYTE, b);
	endfunction

	always_comb begin
		parse_state_t s;
		pair_t p;
		s = start_of_request ? STATE_RESET : cur;
		p = '0;
		unique case (s.phase)
			PH_METHOD: begin
				method_step(data_byte, ext_en, s, p);
			end
			PH_SPACE: begin
				if (data_byte == CH_SP) s.phase = PH_PATH;
				else go_error(s, p);
			end
			PH_PATH: begin
				path_step(data_byte, s, p);
			end
			PH_PROTO: begin
				if (s.pos < PROTO_LEN && proto_char(s.pos) == data_byte) begin
					s.pos = s.pos + 3'd1;
					if (s.pos == PROTO_LEN) begin
						s.phase = PH_SKIP;
						s.pos = 3'd0;
						s.hcr = 1'b0;
					end
				end else begin
					go_error(s, p);
				end
			end
			PH_SKIP: begin
				if (s.hcr && data_byte == CH_LF) begin
					s.hcr = 1'b0;
					s.phase = PH_LINE_START;
				end else begin
					s.hcr = (data_byte == CH_CR);
				end
			end
			PH_LINE_START: begin
				if (s.hcr) begin
					s.hcr = 1'b0;
					if (data_byte == CH_LF) begin
						p = emit(p, EV_HEADERS_DONE, 8'h00);
						s.phase = PH_DONE;
					end else begin
						p = emit(p, EV_NAME_BYTE, CH_CR);
						s.phase = PH_NAME;
						name_step(data_byte, s, p);
					end
				end else if (data_byte == CH_CR) begin
					s.hcr = 1'b1;
				end else begin
					s.phase = PH_NAME;
					name_step(data_byte, s, p);
				end
			end
			PH_NAME: begin
				name_step(data_byte, s, p);
			end
			PH_VALUE: begin
				value_step(data_byte, s, p);
			end
			PH_DONE: begin
			end
			default: begin
				s.phase = PH_ERROR;
				p = emit(p, EV_ERROR, 8'h00);
			end
		endcase
		if (p.cnt == 2'd0) p = emit(p, EV_NONE, 8'h00);
		p.r0.method = s.mfound;
		p.r1.method = s.mfound;
		nxt = s;
		res = p;
	end

endmodule

// File: hdl/hrhp_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue of event pairs, drained one event item per cycle while the output is ready.
// ----------------------------------------------------------------------------
module hrhp_result_queue import hrhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pair_t     push_data,
	output logic      push_ready,
	hrhp_out_if.source evt
);

	pair_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       sub_q;
	pair_t      head;
	result_t    cur;
	logic       take;
	logic       pop;

	assign head       = entry_q[rd_ptr_q];
	assign cur        = sub_q ? head.r1 : head.r0;
	assign push_ready = (cnt_q != 2'd2);

	assign evt.valid       = (cnt_q != 2'd0);
	assign evt.event_res   = cur.ev;
	assign evt.out_byte    = cur.data;
	assign evt.method_code = cur.method;
	assign evt.last        = sub_q || (head.cnt != 2'd2);

	assign take = evt.valid && evt.ready;
	assign pop  = take && evt.last;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			sub_q    <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
			if (take) sub_q <= !evt.last;
		end
	end

	a_sub_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (cnt_q != 2'd0) && (head.cnt == 2'd2))
		else $error("second event selected on a single-event entry");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not advance on push");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && !evt.ready) |=> $stable(sub_q) && $stable(rd_ptr_q))
		else $error("queue head moved while output stalled");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("push into full queue");

endmodule

// File: hdl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// HTTP request head parser
// Splits a request head byte stream into method, path and header events.
// ----------------------------------------------------------------------------
// The block takes one request byte per cycle and turns it into one or two event
// items (the last one flagged by last): the parser state register is updated at
// the byte's acceptance and its events go into a two-entry result queue, so a
// byte is taken every cycle while the queue has room, even when the previous
// events still wait on the output. Each event item is a separate output transfer,
// so a byte that yields two events (a held colon or CR emitted ahead of the next
// byte's result, or an early-ended escape) takes two output transfers, and the
// output port sets the sustained byte rate. The extended method enable is
// written through cfg_we/cfg_wdata and takes effect on the next byte.
// ----------------------------------------------------------------------------
module http_request_head_parser import hrhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	hrhp_in_if.sink    req,
	hrhp_out_if.source evt
);

	parse_state_t state_q;
	parse_state_t state_nxt;
	pair_t        step_res;
	logic         ext_en_q;
	logic         push_ready;
	logic         accept;

	assign req.ready = push_ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_en_q <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (cfg_we) ext_en_q <= cfg_wdata;
			if (accept) state_q <= state_nxt;
		end
	end

	hrhp_step u_step (
		.cur              (state_q),
		.data_byte        (req.data_byte),
		.start_of_request (req.start_of_request),
		.ext_en           (ext_en_q),
		.nxt              (state_nxt),
		.res              (step_res)
	);

	hrhp_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (step_res),
		.push_ready (push_ready),
		.evt        (evt)
	);

endmodule

// File: test/http_request_head_parser_test.sv
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Streams request heads (directed cases, then random well-formed requests
// mixed with corrupted ones) through the byte channel under random sender
// bursts and receiver stalls, predicts every parse event in a model of the
// parser kept here, and checks each event item in order as it leaves.
// ----------------------------------------------------------------------------
module http_request_head_parser_test import hrhp_pkg::*;;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 150;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [3:0] ev;
		logic [7:0] data;
		logic [2:0] method;
		logic       last;
	} parse_event_t;

	typedef struct packed {
		logic [7:0] b;
		logic       sor;
	} req_byte_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	hrhp_in_if  req_if ();
	hrhp_out_if evt_if ();

	http_request_head_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.evt       (evt_if)
	);

	string method_names [8] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT",
		"OPTIONS", "TRACE"};
	string proto_word = "HTTP/";
	string hex_chars = "0123456789abcdefABCDEF";

	req_byte_t    request_bytes [$];
	parse_event_t expected_events [$];
	logic [7:0]   draft [$];
	parse_event_t step_buf [2];
	int           step_n;

	logic [3:0] ps_phase;
	logic [7:0] ps_cand;
	logic [2:0] ps_pos;
	logic [2:0] ps_method;
	logic [7:0] ps_esc;
	logic [1:0] ps_digits;
	logic       ps_colon;
	logic       ps_cr;
	logic       ext_methods;

	int   bytes_queued;
	int   bytes_in;
	int   mismatches;
	int   idle_cycles;
	logic byte_taken;
	int   burst_left;
	int   gap_left;
	int   hold_left;
	int   next_hold_at;
	logic [7:0] ready_pattern;

	always #5 clk = ~clk;

	task automatic add_event(input logic [3:0] ev, input logic [7:0] d);
		if (step_n < 2) begin
			step_buf[step_n] = '{ev: ev, data: d, method: ps_method, last: 1'b0};
			step_n++;
		end
	endtask

	task automatic clear_parse();
		ps_phase = PH_METHOD;
		ps_cand = 8'hff;
		ps_pos = 3'd0;
		ps_method = 3'd0;
		ps_esc = 8'h00;
		ps_digits = 2'd0;
		ps_colon = 1'b0;
		ps_cr = 1'b0;
	endtask

	task automatic enter_error();
		ps_phase = PH_ERROR;
		ps_digits = 2'd0;
		ps_esc = 8'h00;
		ps_colon = 1'b0;
		ps_cr = 1'b0;
		add_event(EV_ERROR, 8'h00);
	endtask

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "a" && c <= "f") return int'(c) - 87;
		if (c >= "A" && c <= "F") return int'(c) - 55;
		return -1;
	endfunction

	task automatic match_method(input logic [7:0] b);
		logic [7:0] allowed;
		logic [7:0] keep;
		logic found;
		string nm;
		allowed = ps_cand & (ext_methods ? 8'hff : BASIC_METHOD_MASK);
		keep = 8'h00;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			nm = method_names[i];
			if (!found && allowed[i] && nm.len() > ps_pos && nm[ps_pos] == b) begin
				keep[i] = 1'b1;
				if (nm.len() == ps_pos + 1) begin
					found = 1'b1;
					ps_method = 3'(i);
					ps_phase = PH_SPACE;
					add_event(EV_METHOD, 8'h00);
				end
			end
		end
		if (!found) begin
			if (keep == 8'h00) begin
				enter_error();
			end else begin
				ps_cand = keep;
				ps_pos = ps_pos + 3'd1;
			end
		end
	endtask

	task automatic path_byte(input logic [7:0] b);
		int d;
		logic done;
		done = 1'b0;
		if (ps_digits != 2'd0) begin
			d = hex_digit(b);
			if (d >= 0) begin
				ps_esc = {ps_esc[3:0], 4'(d)};
				if (ps_digits == 2'd2) begin
					add_event(EV_URL_BYTE, ps_esc);
					ps_digits = 2'd0;
					ps_esc = 8'h00;
				end else begin
					ps_digits = 2'd2;
				end
				done = 1'b1;
			end else begin
				add_event(EV_URL_BYTE, ps_esc);
				ps_digits = 2'd0;
				ps_esc = 8'h00;
			end
		end else if (ps_cr) begin
			ps_cr = 1'b0;
			if (b == CH_LF) begin
				enter_error();
				done = 1'b1;
			end else begin
				add_event(EV_URL_BYTE, CH_CR);
			end
		end
		if (!done) begin
			if (b == CH_SP) begin
				add_event(EV_URL_END, 8'h00);
				ps_phase = PH_PROTO;
				ps_pos = 3'd0;
			end else if (b == CH_PCT) begin
				ps_digits = 2'd1;
				ps_esc = 8'h00;
			end else if (b == CH_CR) begin
				ps_cr = 1'b1;
			end else begin
				add_event(EV_URL_BYTE, b);
			end
		end
	endtask

	task automatic name_byte(input logic [7:0] b);
		logic done;
		done = 1'b0;
		if (ps_colon) begin
			ps_colon = 1'b0;
			if (b == CH_SP) begin
				ps_phase = PH_VALUE;
				done = 1'b1;
			end else begin
				add_event(EV_NAME_BYTE, CH_COLON);
			end
		end else if (ps_cr) begin
			ps_cr = 1'b0;
			if (b == CH_LF) begin
				add_event(EV_LINE_SKIPPED, 8'h00);
				ps_phase = PH_LINE_START;
				done = 1'b1;
			end else begin
				add_event(EV_NAME_BYTE, CH_CR);
			end
		end
		if (!done) begin
			if (b == CH_COLON) ps_colon = 1'b1;
			else if (b == CH_CR) ps_cr = 1'b1;
			else add_event(EV_NAME_BYTE, b);
		end
	endtask

	task automatic value_byte(input logic [7:0] b);
		logic done;
		done = 1'b0;
		if (ps_cr) begin
			ps_cr = 1'b0;
			if (b == CH_LF) begin
				add_event(EV_FIELD_END, 8'h00);
				ps_phase = PH_LINE_START;
				done = 1'b1;
			end else begin
				add_event(EV_VALUE_BYTE, CH_CR);
			end
		end
		if (!done) begin
			if (b == CH_CR) ps_cr = 1'b1;
			else add_event(EV_VALUE_BYTE, b);
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic sor);
		step_n = 0;
		if (sor) clear_parse();
		case (ps_phase)
			PH_METHOD: match_method(b);
			PH_SPACE: begin
				if (b == CH_SP) ps_phase = PH_PATH;
				else enter_error();
			end
			PH_PATH: path_byte(b);
			PH_PROTO: begin
				if (ps_pos < PROTO_LEN && proto_word[ps_pos] == b) begin
					ps_pos = ps_pos + 3'd1;
					if (ps_pos == PROTO_LEN) begin
						ps_phase = PH_SKIP;
						ps_pos = 3'd0;
						ps_cr = 1'b0;
					end
				end else begin
					enter_error();
				end
			end
			PH_SKIP: begin
				if (ps_cr && b == CH_LF) begin
					ps_cr = 1'b0;
					ps_phase = PH_LINE_START;
				end else begin
					ps_cr = (b == CH_CR);
				end
			end
			PH_LINE_START: begin
				if (ps_cr) begin
					ps_cr = 1'b0;
					if (b == CH_LF) begin
						add_event(EV_HEADERS_DONE, 8'h00);
						ps_phase = PH_DONE;
					end else begin
						add_event(EV_NAME_BYTE, CH_CR);
						ps_phase = PH_NAME;
						name_byte(b);
					end
				end else if (b == CH_CR) begin
					ps_cr = 1'b1;
				end else begin
					ps_phase = PH_NAME;
					name_byte(b);
				end
			end
			PH_NAME: name_byte(b);
			PH_VALUE: value_byte(b);
			PH_DONE: ;
			default: begin
				ps_phase = PH_ERROR;
				add_event(EV_ERROR, 8'h00);
			end
		endcase
		if (step_n == 0) add_event(EV_NONE, 8'h00);
		step_buf[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++) expected_events.push_back(step_buf[i]);
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	task automatic put_byte(input logic [7:0] b, input logic sor);
		request_bytes.push_back('{b: b, sor: sor});
		bytes_queued++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
	endtask

	function automatic logic [7:0] letter();
		return 8'($urandom_range(97, 122));
	endfunction

	task automatic gen_request();
		int n;
		int nv;
		int sel;
		int kind;
		int cut;
		string nm;
		draft.delete();
		nm = method_names[$urandom_range(0, 7)];
		add_text(nm);
		draft.push_back(CH_SP);
		n = $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 15);
			if (sel < 8) begin
				draft.push_back(letter());
			end else if (sel == 8) begin
				draft.push_back("/");
			end else if (sel < 11) begin
				draft.push_back(CH_PCT);
				for (int j = $urandom_range(0, 2); j > 0; j--)
					draft.push_back(hex_chars[$urandom_range(0, 21)]);
			end else if (sel == 11) begin
				draft.push_back(CH_CR);
			end else if (sel == 12) begin
				draft.push_back(CH_LF);
			end else begin
				draft.push_back(8'($urandom));
			end
		end
		add_text(" HTTP/1.");
		draft.push_back(8'($urandom_range(48, 57)));
		if ($urandom_range(0, 3) == 0) begin
			draft.push_back(CH_CR);
			draft.push_back(8'($urandom));
		end
		draft.push_back(CH_CR);
		draft.push_back(CH_LF);
		for (int h = $urandom_range(0, 4); h > 0; h--) begin
			kind = $urandom_range(0, 7);
			if (kind == 0) draft.push_back(CH_CR);
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				sel = $urandom_range(0, 11);
				if (sel < 8) draft.push_back(letter());
				else if (sel == 8) draft.push_back(8'h2d);
				else if (sel == 9) draft.push_back(CH_COLON);
				else if (sel == 10) draft.push_back(CH_CR);
				else draft.push_back(8'($urandom));
			end
			if (kind != 1) begin
				draft.push_back(CH_COLON);
				draft.push_back(CH_SP);
				nv = $urandom_range(0, 10);
				for (int i = 0; i < nv; i++) begin
					sel = $urandom_range(0, 11);
					if (sel < 9) draft.push_back(8'($urandom_range(33, 126)));
					else if (sel == 9) draft.push_back(CH_CR);
					else if (sel == 10) draft.push_back(CH_SP);
					else draft.push_back(8'($urandom));
				end
			end
			draft.push_back(CH_CR);
			draft.push_back(CH_LF);
		end
		draft.push_back(CH_CR);
		draft.push_back(CH_LF);
		if ($urandom_range(0, 4) == 0)
			for (int i = $urandom_range(1, 3); i > 0; i--) draft.push_back(8'($urandom));
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			cut = $urandom_range(1, draft.size());
			while (draft.size() > cut) draft.delete(draft.size() - 1);
		end else if (sel < 4) begin
			draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom);
		end
		for (int i = 0; i < draft.size(); i++) put_byte(draft[i], i == 0 && sel != 4);
	endtask

	task automatic wait_drained();
		while (request_bytes.size() != 0 || req_if.valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_ext_enable(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver: hold the byte until taken, bursts separated by random gaps
	always @(negedge clk) begin
		req_byte_t nxt;
		if (arst_n && (byte_taken || !req_if.valid)) begin
			if (gap_left != 0 || request_bytes.size() == 0) begin
				req_if.valid <= 1'b0;
				if (gap_left != 0) gap_left--;
			end else begin
				nxt = request_bytes.pop_front();
				req_if.data_byte <= nxt.b;
				req_if.start_of_request <= nxt.sor;
				req_if.valid <= 1'b1;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: rotating stall pattern, plus long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			evt_if.ready <= 1'b0;
			hold_left--;
		end else if (bytes_in >= next_hold_at) begin
			evt_if.ready <= 1'b0;
			hold_left = LONG_HOLD;
			next_hold_at = next_hold_at + 600;
		end else begin
			if ($urandom_range(0, 47) == 0) begin
				ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
				if (ready_pattern == 8'h00) ready_pattern = 8'h81;
			end
			ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
			evt_if.ready <= ready_pattern[0];
		end
	end

	// monitor: predict on each taken byte, check each event item
	always @(posedge clk) begin
		parse_event_t got;
		parse_event_t want;
		logic progress;
		progress = 1'b0;
		byte_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we) ext_methods = cfg_wdata;
			if (req_if.valid && req_if.ready) begin
				predict_byte(req_if.data_byte, req_if.start_of_request);
				byte_taken = 1'b1;
				bytes_in++;
				progress = 1'b1;
			end
			if (evt_if.valid && evt_if.ready) begin
				progress = 1'b1;
				got = '{ev: evt_if.event_res, data: evt_if.out_byte,
					method: evt_if.method_code, last: evt_if.last};
				if (expected_events.size() == 0) begin
					note_failure($sformatf("unexpected event %0d byte %02h method %0d last %0b",
						got.ev, got.data, got.method, got.last));
				end else begin
					want = expected_events.pop_front();
					if (got !== want)
						note_failure($sformatf(
							"event mismatch: expected %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
							want.ev, want.data, want.method, want.last,
							got.ev, got.data, got.method, got.last));
				end
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_if.valid = 1'b0;
		req_if.data_byte = 8'h00;
		req_if.start_of_request = 1'b0;
		evt_if.ready = 1'b0;
		bytes_queued = 0;
		bytes_in = 0;
		mismatches = 0;
		idle_cycles = 0;
		byte_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		next_hold_at = 300;
		ready_pattern = 8'hff;
		ext_methods = 1'b0;
		clear_parse();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_ext_enable(1'b0);
		put_byte("X", 1'b1);
		put_byte("A", 1'b0);
		put_byte("G", 1'b1);
		put_text("ETx");
		put_byte("H", 1'b1);
		put_text("EAD /%4g%FF%");
		put_byte(CH_CR, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_LF, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'hff, 1'b0);
		while (bytes_queued < 350) gen_request();
		wait_drained();

		write_ext_enable(1'b1);
		while (bytes_queued < 700) gen_request();
		put_byte("C", 1'b1);
		wait_drained();

		// candidates narrowed to an extended method, then the mask drops it
		write_ext_enable(1'b0);
		put_byte("O", 1'b0);
		while (bytes_queued < 1000) gen_request();
		wait_drained();

		write_ext_enable(1'b1);
		while (bytes_queued < 1300) gen_request();
		wait_drained();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hdl/hrhp_pkg.sv
hdl/hrhp_in_if.sv
hdl/hrhp_out_if.sv
hdl/hrhp_step.sv
hdl/hrhp_result_queue.sv
hdl/http_request_head_parser.sv
test/http_request_head_parser_test.sv
